// File: hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SFDG_ASSERT_IMP(lbl, clk, rst_n, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SFDG_ASSERT_NXT(lbl, clk, rst_n, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error(msg);

`endif

// File: hdl/sfdg_pkg.sv
package sfdg_pkg;

  // Defaults for the top-level parameters
  localparam int DIGIT_STORE_DEF = 24;
  localparam int WORK_WIDTH_DEF  = 128;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;

  // Decoded operand widths
  localparam int MANT_W = 53;
  localparam int E2_W   = 12;
  localparam int SH_W   = 7;
  localparam int K_W    = 8;
  localparam int DIGIT_W = 4;
  localparam int DEXP_W  = 7;

  // Generator limits
  localparam int MAX_DIG_DBL    = 17;
  localparam int MAX_DIG_SGL    = 9;
  localparam int E2_MAX         = 75;
  localparam int SCALE_BITS_MAX = 96;
  localparam int GUARD_LIMIT    = 24;
  localparam int GUARD_W        = 5;

  typedef enum logic [2:0] {
    ST_DIGITS = 3'd0,
    ST_ZERO   = 3'd1,
    ST_INF    = 3'd2,
    ST_NAN    = 3'd3,
    ST_TIER   = 3'd4
  } status_e;

  typedef struct packed {
    logic                     sign;
    status_e                  cls;
    logic [MANT_W-1:0]        mant;
    logic signed [E2_W-1:0]   e2;
    logic                     pow2;
    logic                     single;
  } item_t;

endpackage

// File: hdl/shortest_float_digit_generator_core.sv
// Shortest round-trip decimal digits for binary64 and binary32 values.
// Input stream: one beat per value, tdata holds the IEEE pattern, tuser
// selects binary32 (low 32 bits used). Output stream: one beat per digit,
// most significant first, with sign and decimal exponent k (value is
// 0.digits x 10^k); tlast marks the final digit. Zero, infinity, NaN and
// values beyond the 128-bit working range give a single beat with tuser
// set to the status code and tlast high.
// A special value is classified and then presented as a status beat. A
// digit string passes through setup (with a doubling step for a power of
// two), upward scaling steps of the value, growth steps of the scale, a
// multiply, subtract loop, store and decision per generated digit, a tie
// decision, a read and check per carry position and a read and output per
// emitted digit. The digit loop subtracts the scale at the 128-bit working
// width; one value is worked on at a time.
// A two-entry queue ahead of the generator takes new values while it works.
// When the receiver stalls, the output beat holds and generation pauses.
// Reset empties the queue and returns the generator to idle.
module shortest_float_digit_generator_core
  import sfdg_pkg::*;
#(
  parameter int DIGIT_STORE = DIGIT_STORE_DEF,
  parameter int WORK_WIDTH  = WORK_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // raw_bits[63:0]
  input  logic        s_axis_tuser_i,   // is_single[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // sign[0], digit[4:1], dec_exponent[11:5], zero[15:12]
  output logic [2:0]  m_axis_tuser_o,   // status[2:0]
  output logic        m_axis_tlast_o
);

  item_t               front_item, queue_item;
  logic                queue_valid, back_ready;
  logic                out_sign;
  logic [DIGIT_W-1:0]  out_digit;
  logic [DEXP_W-1:0]   out_dexp;
  status_e             out_status;

  sfdg_front u_front (
    .raw_bits_i  (s_axis_tdata_i),
    .is_single_i (s_axis_tuser_i),
    .item_o      (front_item)
  );

  sfdg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid_i),
    .push_item_i  (front_item),
    .push_ready_o (s_axis_tready_o),
    .pop_valid_o  (queue_valid),
    .pop_item_o   (queue_item),
    .pop_ready_i  (back_ready)
  );

  sfdg_back #(
    .DIGIT_STORE (DIGIT_STORE),
    .WORK_WIDTH  (WORK_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .item_ready_o (back_ready),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_sign_o   (out_sign),
    .out_digit_o  (out_digit),
    .out_dexp_o   (out_dexp),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast_o)
  );

  // Pack the result beat
  assign m_axis_tdata_o = {4'd0, out_dexp, out_digit, out_sign};
  assign m_axis_tuser_o = out_status;

endmodule

// File: hdl/sfdg_front.sv
module sfdg_front
  import sfdg_pkg::*;
(
  input  logic [63:0] raw_bits_i,
  input  logic        is_single_i,
  output item_t       item_o
);

  localparam logic [10:0] EXP_MAX_DBL = 11'h7FF;
  localparam logic [7:0]  EXP_MAX_SGL = 8'hFF;
  localparam logic signed [E2_W-1:0] BIAS_DBL   = 12'sd1075;
  localparam logic signed [E2_W-1:0] DENORM_DBL = -12'sd1074;
  localparam logic signed [E2_W-1:0] BIAS_SGL   = 12'sd150;
  localparam logic signed [E2_W-1:0] DENORM_SGL = -12'sd149;

  logic              exp_nz;
  logic              mant_nz;
  logic              max_exp;
  logic [MANT_W-1:0] mant_m;

  // Split the pattern into sign, exponent and significand
  always_comb begin
    item_o = '0;
    if (is_single_i) begin
      item_o.sign = raw_bits_i[31];
      exp_nz  = |raw_bits_i[30:23];
      mant_nz = |raw_bits_i[22:0];
      max_exp = raw_bits_i[30:23] == EXP_MAX_SGL;
      mant_m  = {29'd0, exp_nz, raw_bits_i[22:0]};
      item_o.e2 = exp_nz ? $signed({4'd0, raw_bits_i[30:23]}) - BIAS_SGL : DENORM_SGL;
    end else begin
      item_o.sign = raw_bits_i[63];
      exp_nz  = |raw_bits_i[62:52];
      mant_nz = |raw_bits_i[51:0];
      max_exp = raw_bits_i[62:52] == EXP_MAX_DBL;
      mant_m  = {exp_nz, raw_bits_i[51:0]};
      item_o.e2 = exp_nz ? $signed({1'b0, raw_bits_i[62:52]}) - BIAS_DBL : DENORM_DBL;
    end
    item_o.mant   = mant_m;
    item_o.pow2   = exp_nz && !mant_nz;
    item_o.single = is_single_i;
    // Classify specials before any digit work
    if (max_exp) begin
      item_o.cls = mant_nz ? ST_NAN : ST_INF;
    end else if (mant_m == '0) begin
      item_o.cls = ST_ZERO;
    end else begin
      item_o.cls = ST_DIGITS;
    end
  end

endmodule

// File: hdl/sfdg_queue.sv
module sfdg_queue
  import sfdg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  item_t push_item_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output item_t pop_item_o,
  input  logic  pop_ready_i
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  item_t            entry_q [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     count_q;
  logic             push, pop;

  assign push_ready_o = count_q != (QAW+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Store pushed beats
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

// File: hdl/sfdg_back.sv
module sfdg_back
  import sfdg_pkg::*;
#(
  parameter int DIGIT_STORE = DIGIT_STORE_DEF,
  parameter int WORK_WIDTH  = WORK_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  item_t               item_i,
  output logic                item_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_sign_o,
  output logic [DIGIT_W-1:0]  out_digit_o,
  output logic [DEXP_W-1:0]   out_dexp_o,
  output status_e             out_status_o,
  output logic                out_last_o
);

  localparam int W  = WORK_WIDTH;
  localparam int AW = $clog2(DIGIT_STORE);
  localparam int NW = $clog2(DIGIT_STORE + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_POW2, S_LOW, S_LOWM, S_HIGH, S_DMUL, S_DSUB,
    S_DSTORE, S_DDEC, S_DTIE, S_CRD, S_CCHK, S_EMRD, S_EMOUT, S_STAT
  } state_e;

  // Shift left, reporting lost bits in the top bit
  function automatic logic [W:0] shl_f(input logic [W-1:0] x, input logic [SH_W-1:0] sh);
    logic [2*W-1:0] e;
    e = {{W{1'b0}}, x} << sh;
    return {|e[2*W-1:W], e[W-1:0]};
  endfunction

  // Times ten as 8x + 2x, reporting overflow in the top bit
  function automatic logic [W:0] mul10_f(input logic [W-1:0] x);
    logic [W+3:0] p;
    p = ({4'd0, x} << 3) + ({4'd0, x} << 1);
    return {|p[W+3:W], p[W-1:0]};
  endfunction

  state_e                  state_q, state_d;
  logic                    sign_q, sign_d;
  status_e                 status_q, status_d;
  logic [MANT_W-1:0]       m_q, m_d;
  logic signed [E2_W-1:0]  e2_q, e2_d;
  logic                    pow2_q, pow2_d;
  logic                    single_q, single_d;
  logic [W-1:0]            r_q, r_d, s_q, s_d, mm_q, mm_d, mp_q, mp_d, t_q, t_d;
  logic signed [K_W-1:0]   k_q, k_d;
  logic [GUARD_W-1:0]      guard_q, guard_d;
  logic [NW-1:0]           n_q, n_d, em_q, em_d;
  logic [DIGIT_W-1:0]      d_q, d_d;
  logic [AW-1:0]           ci_q, ci_d;
  logic                    lead_q, lead_d;
  logic                    cd_lt_q, cd_lt_d, cd_eq_q, cd_eq_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_sign_q, out_sign_d;
  logic [DIGIT_W-1:0]      out_digit_q, out_digit_d;
  logic [DEXP_W-1:0]       out_dexp_q, out_dexp_d;
  status_e                 out_status_q, out_status_d;
  logic                    out_last_q, out_last_d;

  // Digit store
  logic [DIGIT_W-1:0]      mem [DIGIT_STORE];
  logic [DIGIT_W-1:0]      rd_data_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa, rd_addr;
  logic [DIGIT_W-1:0]      mem_wd;

  // Datapath terms
  logic [W-1:0]            m_w;
  logic                    e2_pos, e2_zero, e2_neg, out_of_range;
  logic signed [E2_W-1:0]  bits, e2m1;
  logic [SH_W-1:0]         sh_r, sh_o;
  logic [W:0]              r_sh, o_sh, r10, mm10, mp10, s10, sum_rm;
  logic                    out_free, even, round_dn, can_up, tie_c_gt, tie_c_eq;
  logic [NW-1:0]           max_dig, n_m1, total_m1;

  assign m_w      = {{(W-MANT_W){1'b0}}, m_q};
  assign e2_pos   = e2_q > 0;
  assign e2_zero  = e2_q == 0;
  assign e2_neg   = e2_q < 0;
  assign bits     = 12'sd1 - e2_q;
  assign e2m1     = e2_q - 12'sd1;
  assign out_of_range = (e2_q > E2_MAX) || (e2_neg && (bits > SCALE_BITS_MAX));
  assign sh_r     = e2_pos ? e2_q[SH_W-1:0] : SH_W'(1);
  assign sh_o     = e2_pos ? e2m1[SH_W-1:0] : bits[SH_W-1:0];
  assign r_sh     = shl_f(m_w, sh_r);
  assign o_sh     = shl_f(W'(1), sh_o);
  assign r10      = mul10_f(r_q);
  assign mm10     = mul10_f(mm_q);
  assign mp10     = mul10_f(mp_q);
  assign s10      = mul10_f(s_q);
  assign sum_rm   = {1'b0, r_q} + {1'b0, mp_q};
  assign even     = !m_q[0];
  assign round_dn = cd_lt_q || (even && cd_eq_q);
  assign can_up   = (t_q < mp_q) || (even && (t_q == mp_q));
  // Round-half check: compare 2r with s, a carry out means above
  assign tie_c_gt = r_q[W-1] || ({r_q[W-2:0], 1'b0} > s_q);
  assign tie_c_eq = !r_q[W-1] && ({r_q[W-2:0], 1'b0} == s_q);
  assign max_dig  = single_q ? NW'(MAX_DIG_SGL) : NW'(MAX_DIG_DBL);
  assign n_m1     = n_q - NW'(1);
  assign total_m1 = n_q + NW'(lead_q) - NW'(1);
  assign out_free = !out_valid_q || out_ready_i;

  assign item_ready_o = state_q == S_IDLE;
  assign out_valid_o  = out_valid_q;
  assign out_sign_o   = out_sign_q;
  assign out_digit_o  = out_digit_q;
  assign out_dexp_o   = out_dexp_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

  // Sequencer next state
  always_comb begin
    state_d  = state_q;
    sign_d   = sign_q;
    status_d = status_q;
    m_d      = m_q;
    e2_d     = e2_q;
    pow2_d   = pow2_q;
    single_d = single_q;
    r_d      = r_q;
    s_d      = s_q;
    mm_d     = mm_q;
    mp_d     = mp_q;
    t_d      = t_q;
    k_d      = k_q;
    guard_d  = guard_q;
    n_d      = n_q;
    em_d     = em_q;
    d_d      = d_q;
    ci_d     = ci_q;
    lead_d   = lead_q;
    cd_lt_d  = cd_lt_q;
    cd_eq_d  = cd_eq_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sign_d   = out_sign_q;
    out_digit_d  = out_digit_q;
    out_dexp_d   = out_dexp_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    mem_we   = 1'b0;
    mem_wa   = n_q[AW-1:0];
    mem_wd   = d_q;
    rd_addr  = ci_q;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          sign_d   = item_i.sign;
          status_d = item_i.cls;
          m_d      = item_i.mant;
          e2_d     = $signed(item_i.e2);
          pow2_d   = item_i.pow2;
          single_d = item_i.single;
          state_d  = S_CLASS;
        end
      end
      S_CLASS: begin
        k_d     = '0;
        guard_d = '0;
        n_d     = '0;
        lead_d  = 1'b0;
        if (status_q != ST_DIGITS) begin
          state_d = S_STAT;
        end else if (out_of_range) begin
          status_d = ST_TIER;
          state_d  = S_STAT;
        end else begin
          r_d = r_sh[W-1:0];
          if (e2_pos) begin
            s_d  = W'(1);
            mp_d = o_sh[W-1:0];
            mm_d = o_sh[W-1:0];
          end else if (e2_zero) begin
            s_d  = W'(2);
            mp_d = W'(1);
            mm_d = W'(1);
          end else begin
            s_d  = o_sh[W-1:0];
            mp_d = W'(1);
            mm_d = W'(1);
          end
          if (r_sh[W] || (!e2_zero && o_sh[W])) begin
            status_d = ST_TIER;
            state_d  = S_STAT;
          end else begin
            state_d = pow2_q ? S_POW2 : S_LOW;
          end
        end
      end
      // Double r, s and the high margin for a power of two
      S_POW2: begin
        r_d  = {r_q[W-2:0], 1'b0};
        s_d  = {s_q[W-2:0], 1'b0};
        mp_d = {mp_q[W-2:0], 1'b0};
        if (r_q[W-1] || s_q[W-1] || mp_q[W-1]) begin
          status_d = ST_TIER;
          state_d  = S_STAT;
        end else begin
          state_d = S_LOW;
        end
      end
      S_LOW: begin
        if (sum_rm[W] || (sum_rm[W-1:0] > s_q)) begin
          guard_d = '0;
          state_d = S_HIGH;
        end else begin
          state_d = S_LOWM;
        end
      end
      // Scale value and margins up by ten
      S_LOWM: begin
        if (r10[W] || mm10[W] || mp10[W] || (guard_q >= GUARD_W'(GUARD_LIMIT))) begin
          status_d = ST_TIER;
          state_d  = S_STAT;
        end else begin
          r_d     = r10[W-1:0];
          mm_d    = mm10[W-1:0];
          mp_d    = mp10[W-1:0];
          k_d     = k_q - K_W'(1);
          guard_d = guard_q + 1'b1;
          state_d = S_LOW;
        end
      end
      // Grow the scale until the value drops below it
      S_HIGH: begin
        if (r_q >= s_q) begin
          if (s10[W] || (guard_q >= GUARD_W'(GUARD_LIMIT))) begin
            status_d = ST_TIER;
            state_d  = S_STAT;
          end else begin
            s_d     = s10[W-1:0];
            k_d     = k_q + K_W'(1);
            guard_d = guard_q + 1'b1;
          end
        end else begin
          state_d = S_DMUL;
        end
      end
      S_DMUL: begin
        if (r10[W] || mm10[W] || mp10[W]) begin
          status_d = ST_TIER;
          state_d  = S_STAT;
        end else begin
          r_d     = r10[W-1:0];
          mm_d    = mm10[W-1:0];
          mp_d    = mp10[W-1:0];
          d_d     = '0;
          state_d = S_DSUB;
        end
      end
      // One subtract of the scale per cycle forms the digit
      S_DSUB: begin
        if ((d_q != DIGIT_W'(9)) && (r_q >= s_q)) begin
          r_d = r_q - s_q;
          d_d = d_q + 1'b1;
        end else begin
          state_d = S_DSTORE;
        end
      end
      S_DSTORE: begin
        mem_we  = 1'b1;
        n_d     = n_q + 1'b1;
        cd_lt_d = r_q < mm_q;
        cd_eq_d = r_q == mm_q;
        t_d     = s_q - r_q;
        state_d = S_DDEC;
      end
      S_DDEC: begin
        ci_d = n_m1[AW-1:0];
        if (round_dn || can_up) begin
          if (round_dn && can_up) begin
            state_d = S_DTIE;
          end else if (can_up) begin
            state_d = S_CRD;
          end else begin
            em_d    = '0;
            state_d = S_EMRD;
          end
        end else if (n_q >= max_dig) begin
          em_d    = '0;
          state_d = S_EMRD;
        end else if (n_q >= NW'(DIGIT_STORE - 1)) begin
          status_d = ST_TIER;
          state_d  = S_STAT;
        end else begin
          state_d = S_DMUL;
        end
      end
      S_DTIE: begin
        if (tie_c_gt || (tie_c_eq && d_q[0])) begin
          state_d = S_CRD;
        end else begin
          em_d    = '0;
          state_d = S_EMRD;
        end
      end
      S_CRD: begin
        state_d = S_CCHK;
      end
      // Propagate the round-up carry through stored digits
      S_CCHK: begin
        mem_we = 1'b1;
        mem_wa = ci_q;
        if (rd_data_q != DIGIT_W'(9)) begin
          mem_wd  = rd_data_q + 1'b1;
          em_d    = '0;
          state_d = S_EMRD;
        end else begin
          mem_wd = '0;
          if (ci_q == '0) begin
            lead_d  = 1'b1;
            k_d     = k_q + K_W'(1);
            em_d    = '0;
            state_d = S_EMRD;
          end else begin
            ci_d    = ci_q - 1'b1;
            state_d = S_CRD;
          end
        end
      end
      S_EMRD: begin
        rd_addr = em_q[AW-1:0];
        state_d = S_EMOUT;
      end
      S_EMOUT: begin
        rd_addr = em_q[AW-1:0];
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_sign_d   = sign_q;
          out_digit_d  = lead_q ? ((em_q == '0) ? DIGIT_W'(1) : '0) : rd_data_q;
          out_dexp_d   = k_q[DEXP_W-1:0];
          out_status_d = ST_DIGITS;
          out_last_d   = em_q == total_m1;
          em_d         = em_q + 1'b1;
          state_d      = (em_q == total_m1) ? S_IDLE : S_EMRD;
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_sign_d   = sign_q;
          out_digit_d  = '0;
          out_dexp_d   = '0;
          out_status_d = status_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Write and read the digit store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sign_q       <= 1'b0;
      status_q     <= ST_DIGITS;
      m_q          <= '0;
      e2_q         <= '0;
      pow2_q       <= 1'b0;
      single_q     <= 1'b0;
      r_q          <= '0;
      s_q          <= '0;
      mm_q         <= '0;
      mp_q         <= '0;
      t_q          <= '0;
      k_q          <= '0;
      guard_q      <= '0;
      n_q          <= '0;
      em_q         <= '0;
      d_q          <= '0;
      ci_q         <= '0;
      lead_q       <= 1'b0;
      cd_lt_q      <= 1'b0;
      cd_eq_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_sign_q   <= 1'b0;
      out_digit_q  <= '0;
      out_dexp_q   <= '0;
      out_status_q <= ST_DIGITS;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      sign_q       <= sign_d;
      status_q     <= status_d;
      m_q          <= m_d;
      e2_q         <= e2_d;
      pow2_q       <= pow2_d;
      single_q     <= single_d;
      r_q          <= r_d;
      s_q          <= s_d;
      mm_q         <= mm_d;
      mp_q         <= mp_d;
      t_q          <= t_d;
      k_q          <= k_d;
      guard_q      <= guard_d;
      n_q          <= n_d;
      em_q         <= em_d;
      d_q          <= d_d;
      ci_q         <= ci_d;
      lead_q       <= lead_d;
      cd_lt_q      <= cd_lt_d;
      cd_eq_q      <= cd_eq_d;
      out_valid_q  <= out_valid_d;
      out_sign_q   <= out_sign_d;
      out_digit_q  <= out_digit_d;
      out_dexp_q   <= out_dexp_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

endmodule

// File: hdl/sfdg_chk.sv
`include "assert_macros.svh"

module sfdg_chk
  import sfdg_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled result beat stays put
  `SFDG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result beat changed")

  // A status beat ends its value
  `SFDG_ASSERT_IMP(a_status_last, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != ST_DIGITS), m_axis_tlast_o, "status beat without tlast")

  // A status beat carries no digit and no exponent
  `SFDG_ASSERT_IMP(a_status_zero, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != ST_DIGITS), m_axis_tdata_o[11:1] == 11'd0, "status beat with digit data")

  // Digits stay decimal
  `SFDG_ASSERT_IMP(a_digit_range, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o == ST_DIGITS), m_axis_tdata_o[4:1] <= 4'd9, "digit above nine")

endmodule

bind shortest_float_digit_generator_core sfdg_chk u_sfdg_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sfdg_pkg::*;

  typedef logic [127:0] wide_t;

  typedef struct packed {
    logic             sign;
    logic [3:0]       digit;
    logic [6:0]       dec_exp;
    status_e          status;
    logic             last;
  } digit_beat_t;

  typedef struct packed {
    logic [63:0] raw;
    logic        single;
  } float_item_t;

  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  float_item_t pending_floats[$];
  digit_beat_t expected_digits[$];
  logic [3:0]  digit_buf[24];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_cnt = 0;
  int          idle_cycles = 0;
  int          errors = 0;

  shortest_float_digit_generator_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  // Wide arithmetic helpers at the working width
  function automatic bit fits_times_ten(wide_t a);
    logic [131:0] p;
    p = {4'b0, a} * 132'd10;
    return p[131:128] == 4'b0;
  endfunction

  function automatic wide_t times_ten(wide_t a);
    return wide_t'(a * 128'd10);
  endfunction

  function automatic bit shift_loses(inout wide_t a, input int n);
    logic [255:0] t;
    t = {128'b0, a} << n;
    a = t[127:0];
    return |t[255:128];
  endfunction

  // Shortest digit string into digit_buf; n stays 0 when out of tier
  task automatic shortest_digits(input logic [52:0] m, input int e2, input bit pow2,
                                 input bit single, output int n, output int k);
    wide_t r, s, mm, mp, t;
    logic [128:0] sum;
    bit m_even, round_dn, can_up, up;
    int dig_limit, guard, d, c, i;
    m_even = ~m[0];
    dig_limit = single ? MAX_DIG_SGL : MAX_DIG_DBL;
    n = 0;
    k = 0;
    r = wide_t'(m);
    s = 128'd1;
    mp = 128'd1;
    if (e2 >= 0) begin
      if (e2 > E2_MAX) return;
      if (e2 >= 1) begin
        if (shift_loses(r, e2)) return;
        if (shift_loses(mp, e2 - 1)) return;
      end else begin
        if (shift_loses(r, 1)) return;
        s = 128'd2;
      end
    end else begin
      if (1 - e2 > SCALE_BITS_MAX) return;
      if (shift_loses(r, 1)) return;
      if (shift_loses(s, 1 - e2)) return;
    end
    mm = mp;
    if (pow2) begin
      if (shift_loses(r, 1)) return;
      if (shift_loses(s, 1)) return;
      if (shift_loses(mp, 1)) return;
    end
    // Scale up until value plus high margin exceeds the scale
    guard = 0;
    forever begin
      sum = {1'b0, r} + {1'b0, mp};
      if (sum[128] || sum[127:0] > s) break;
      if (!fits_times_ten(r) || !fits_times_ten(mm) || !fits_times_ten(mp)) return;
      r = times_ten(r);
      mm = times_ten(mm);
      mp = times_ten(mp);
      k--;
      guard++;
      if (guard > GUARD_LIMIT) return;
    end
    // Grow the scale until the value drops below it
    guard = 0;
    while (r >= s) begin
      if (!fits_times_ten(s)) return;
      s = times_ten(s);
      k++;
      guard++;
      if (guard > GUARD_LIMIT) return;
    end
    // Emit digits until the remainder falls within a margin
    forever begin
      if (!fits_times_ten(r) || !fits_times_ten(mm) || !fits_times_ten(mp)) begin
        n = 0;
        return;
      end
      r = times_ten(r);
      mm = times_ten(mm);
      mp = times_ten(mp);
      d = 0;
      while (d < 9 && r >= s) begin
        r = r - s;
        d++;
      end
      digit_buf[n] = 4'(d);
      n++;
      t = s - r;
      round_dn = (r < mm) || (m_even && r == mm);
      can_up = (t < mp) || (m_even && t == mp);
      if (round_dn || can_up) begin
        if (round_dn && can_up) begin
          sum = {1'b0, r} + {1'b0, r};
          if (sum[128]) c = 1;
          else c = (sum[127:0] > s) ? 1 : ((sum[127:0] == s) ? 0 : -1);
          up = (c > 0) || (c == 0 && d[0]);
        end else begin
          up = can_up;
        end
        // Round up with carry, lengthening on all nines
        if (up) begin
          i = n - 1;
          forever begin
            if (digit_buf[i] != 4'd9) begin
              digit_buf[i] = digit_buf[i] + 4'd1;
              break;
            end
            digit_buf[i] = 4'd0;
            if (i == 0) begin
              for (int j = n; j > 0; j--) digit_buf[j] = digit_buf[j-1];
              digit_buf[0] = 4'd1;
              n++;
              k++;
              break;
            end
            i--;
          end
        end
        break;
      end
      if (n >= dig_limit) break;
      if (n >= DIGIT_STORE_DEF - 1) begin
        n = 0;
        return;
      end
    end
  endtask

  // Decode one value and queue the beats it should produce
  task automatic predict_float(input logic [63:0] raw_in, input bit single);
    logic [63:0] raw;
    logic sg, maxexp, pow2;
    logic [10:0] ex;
    logic [51:0] mant;
    logic [52:0] m;
    int e2, n, k;
    digit_beat_t b;
    raw = raw_in;
    if (single) begin
      raw[63:32] = '0;
      sg = raw[31];
      ex = {3'b0, raw[30:23]};
      mant = {29'b0, raw[22:0]};
      maxexp = ex == 11'hFF;
      m = (ex != 0) ? {29'b0, 1'b1, raw[22:0]} : {30'b0, raw[22:0]};
      e2 = (ex != 0) ? int'(ex) - 150 : -149;
    end else begin
      sg = raw[63];
      ex = raw[62:52];
      mant = raw[51:0];
      maxexp = ex == 11'h7FF;
      m = (ex != 0) ? {1'b1, mant} : {1'b0, mant};
      e2 = (ex != 0) ? int'(ex) - 1075 : -1074;
    end
    b = '{sign: sg, digit: 4'd0, dec_exp: 7'd0, status: ST_DIGITS, last: 1'b1};
    if (maxexp) begin
      b.status = (mant != 0) ? ST_NAN : ST_INF;
      expected_digits.push_back(b);
      return;
    end
    if (m == 0) begin
      b.status = ST_ZERO;
      expected_digits.push_back(b);
      return;
    end
    pow2 = (ex != 0) && (mant == 0);
    shortest_digits(m, e2, pow2, single, n, k);
    if (n == 0) begin
      b.status = ST_TIER;
      expected_digits.push_back(b);
      return;
    end
    for (int i = 0; i < n; i++) begin
      b.digit = digit_buf[i];
      b.dec_exp = 7'(k);
      b.last = (i == n - 1);
      expected_digits.push_back(b);
    end
  endtask

  // Driver: present pending values, hold a beat until it is taken
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || s_axis_tready_o)) begin
      if (pending_floats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        float_item_t it;
        it = pending_floats.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= it.raw;
        s_axis_tuser_i <= it.single;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver ready, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready_i <= (hold_cnt == 1);
    end else begin
      m_axis_tready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict accepted values, check output beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        predict_float(s_axis_tdata_i, s_axis_tuser_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        digit_beat_t got, want;
        got = '{sign: m_axis_tdata_o[0], digit: m_axis_tdata_o[4:1],
                dec_exp: m_axis_tdata_o[11:5], status: status_e'(m_axis_tuser_o),
                last: m_axis_tlast_o};
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, got);
          errors++;
        end else begin
          want = expected_digits.pop_front();
          if (got.sign !== want.sign)
            $display("%0t: sign exp %0d got %0d", $time, want.sign, got.sign);
          if (got.digit !== want.digit)
            $display("%0t: digit exp %0d got %0d", $time, want.digit, got.digit);
          if (got.dec_exp !== want.dec_exp)
            $display("%0t: dec_exponent exp %0d got %0d", $time,
                     $signed(want.dec_exp), $signed(got.dec_exp));
          if (got.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          if (got.last !== want.last)
            $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
          if (got !== want) errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat while work is outstanding
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (pending_floats.size() == 0 && expected_digits.size() == 0 && !s_axis_tvalid_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_float(input logic [63:0] raw, input bit single);
    pending_floats.push_back('{raw: raw, single: single});
  endtask

  // Random value, mostly inside the working range
  task automatic add_random_float();
    logic [63:0] raw;
    int sel;
    raw = {$urandom, $urandom};
    sel = $urandom_range(9);
    if (sel < 5) begin
      raw[62:52] = 11'($urandom_range(1155, 975));
      if ($urandom_range(7) == 0) raw[51:0] = '0;
      add_float(raw, 1'b0);
    end else if (sel < 8) begin
      raw[30:23] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(200, 60));
      if ($urandom_range(7) == 0) raw[22:0] = '0;
      add_float(raw, 1'b1);
    end else begin
      add_float(raw, 1'($urandom));
    end
  endtask

  task automatic drain();
    wait (pending_floats.size() == 0 && !s_axis_tvalid_i && expected_digits.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: specials, extremes, powers of two, e2 of zero, wrapped high bits
    add_float(64'h0000_0000_0000_0000, 1'b0);
    add_float(64'h8000_0000_0000_0000, 1'b0);
    add_float(64'h7FF0_0000_0000_0000, 1'b0);
    add_float(64'hFFF0_0000_0000_0000, 1'b0);
    add_float(64'h7FF8_0000_0000_0000, 1'b0);
    add_float(64'h7FF0_0000_0000_0001, 1'b0);
    add_float(64'h3FF0_0000_0000_0000, 1'b0);
    add_float(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    add_float(64'h0000_0000_0000_0001, 1'b0);
    add_float(64'h4330_0000_0000_0000, 1'b0);
    add_float(64'h4330_0000_0000_0001, 1'b0);
    add_float(64'hC000_0000_0000_0000, 1'b0);
    add_float(64'h3FB9_9999_9999_999A, 1'b0);
    add_float(64'h4415_AF1D_78B5_8C40, 1'b0);
    add_float(64'h3FEF_FFFF_FFFF_FFFF, 1'b0);
    add_float(64'h433F_FFFF_FFFF_FFFF, 1'b0);
    add_float(64'h0000_0000_0000_0000, 1'b1);
    add_float(64'hFFFF_FFFF_8000_0000, 1'b1);
    add_float(64'h0000_0000_7F80_0000, 1'b1);
    add_float(64'h0000_0000_7FC0_0000, 1'b1);
    add_float(64'h0000_0000_3F80_0000, 1'b1);
    add_float(64'h0000_0000_7F7F_FFFF, 1'b1);
    add_float(64'h0000_0000_0000_0001, 1'b1);
    add_float(64'hFFFF_FFFF_3DCC_CCCD, 1'b1);
    add_float(64'h0000_0000_4B00_0000, 1'b1);
    add_float(64'h1234_5678_4B7F_FFFF, 1'b1);
    drain();

    // Random phases: free flow, sender idle, receiver stall with hold-off, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 50 : ((ph == 3) ? 15 : 0);
      recv_stall_pct = (ph == 2) ? 50 : ((ph == 3) ? 15 : 0);
      for (int i = 0; i < 24; i++) add_random_float();
      if (ph == 2) begin
        @(posedge clk_i);
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
